// ===== rtl/hufd_pkg.sv =====
// ----------------------------------------------------------------------------
// hufd_pkg: shared types and constants of the Huffman table decoder
// Table size, code length limits, field widths, function codes and the
// request structs that pass between the sequencer and the code table.
// ----------------------------------------------------------------------------
package hufd_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_CODE_LEN  = 24;

  localparam int BYTE_W   = 8;
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 25;
  localparam int IDX_IN_W = 8;

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
  localparam int MARK_W  = MAX_CODE_LEN + 1;
  localparam int CMP_W   = (MARK_W > CODE_W) ? MARK_W : CODE_W;
  localparam int RANGE_W = ((IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W) + 2;
  localparam int BIT_W   = $clog2(BYTE_W);

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [CODE_W-1:0] code;
    logic [SYM_W-1:0]  symbol;
  } tbl_wr_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [SYM_W-1:0]  symbol;
  } tbl_rd_t;

endpackage

// ===== rtl/hufd_if.sv =====
// ----------------------------------------------------------------------------
// hufd_if: request and result channels of the Huffman table decoder
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hufd_in_if;
  import hufd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [IDX_IN_W-1:0]  entry_index;
  logic [CODE_W-1:0]    entry_code;
  logic [SYM_W-1:0]     entry_symbol;
  logic [BYTE_W-1:0]    data_byte;
  logic                 final_byte;

  modport source (
    output valid, func, entry_index, entry_code, entry_symbol, data_byte, final_byte,
    input  ready
  );

  modport sink (
    input  valid, func, entry_index, entry_code, entry_symbol, data_byte, final_byte,
    output ready
  );
endinterface

interface hufd_out_if;
  import hufd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             code_error;
  logic             last_of_run;

  modport source (
    output valid, symbol, code_error, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, symbol, code_error, last_of_run,
    output ready
  );
endinterface

// ===== rtl/hufd_table.sv =====
// ----------------------------------------------------------------------------
// hufd_table: code and symbol store of the Huffman table decoder
// One write port, one registered read port; per-entry valid bits make every
// entry read as empty after reset.
// ----------------------------------------------------------------------------
module hufd_table (
  input  logic                      clk,
  input  logic                      rst,
  input  hufd_pkg::tbl_wr_t         wr,
  input  logic [hufd_pkg::IDX_W-1:0] rd_addr,
  output hufd_pkg::tbl_rd_t         rd
);
  import hufd_pkg::*;

  logic [CODE_W-1:0]        code_mem [TABLE_ENTRIES];
  logic [SYM_W-1:0]         sym_mem  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr.en) begin
      entry_valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      code_mem[wr.addr] <= wr.code;
      sym_mem[wr.addr]  <= wr.symbol;
    end
    rd.code   <= code_mem[rd_addr];
    rd.symbol <= sym_mem[rd_addr];
    if (rst) begin
      rd.valid <= 1'b0;
    end else begin
      rd.valid <= entry_valid[rd_addr];
    end
  end

endmodule

// ===== rtl/hufd_seq.sv =====
// ----------------------------------------------------------------------------
// hufd_seq: bit sequencer and shared code comparator
// Appends one data bit at a time to the pending code, sweeps the table with
// a single comparator, and stages results so the last one of a byte is marked.
// ----------------------------------------------------------------------------
module hufd_seq (
  input  logic                        clk,
  input  logic                        rst,
  hufd_in_if.sink                     din,
  hufd_out_if.source                  dout,
  output hufd_pkg::tbl_wr_t           wr,
  output logic [hufd_pkg::IDX_W-1:0]  rd_addr,
  input  hufd_pkg::tbl_rd_t           rd
);
  import hufd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_COMMIT,
    S_FLUSH
  } state_t;

  state_t                  state;
  logic [BYTE_W-1:0]       byte_q;
  logic                    fin_q;
  logic [BIT_W-1:0]        bit_cnt;
  logic [MAX_CODE_LEN-1:0] pending;
  logic [LEN_W-1:0]        len;
  logic [MARK_W-1:0]       probe;
  logic [IDX_W-1:0]        scan_idx;
  logic                    lag_valid;
  logic                    lag_last;
  logic                    res_valid;
  logic [SYM_W-1:0]        res_symbol;
  logic                    res_err;
  logic                    held_valid;
  logic [SYM_W-1:0]        held_symbol;
  logic                    held_err;
  logic                    out_valid;
  logic [SYM_W-1:0]        out_symbol;
  logic                    out_err;
  logic                    out_last;

  logic                    accept;
  logic                    in_range;
  logic                    out_free;
  logic                    out_load;
  logic                    cur_bit;
  logic [MARK_W-1:0]       onehot;
  logic [MAX_CODE_LEN-1:0] pending_next;
  logic [MARK_W-1:0]       probe_next;
  logic                    hit;
  logic                    scan_end;

  assign din.ready = (state == S_IDLE);
  assign accept    = din.valid && din.ready;
  assign in_range  = RANGE_W'(din.entry_index) < RANGE_W'(TABLE_ENTRIES);

  assign wr.en     = accept && (din.func == FUNC_WRITE) && in_range;
  assign wr.addr   = IDX_W'(din.entry_index);
  assign wr.code   = din.entry_code;
  assign wr.symbol = din.entry_symbol;

  assign rd_addr = scan_idx;

  assign out_free = !out_valid || dout.ready;
  assign out_load = out_free && held_valid &&
                    (((state == S_COMMIT) && res_valid) || (state == S_FLUSH));

  assign cur_bit      = byte_q[bit_cnt];
  assign onehot       = MARK_W'(1) << len;
  assign pending_next = pending | (cur_bit ? onehot[MAX_CODE_LEN-1:0] : '0);
  assign probe_next   = {1'b0, pending_next} | {onehot[MAX_CODE_LEN-1:0], 1'b0};

  assign hit      = lag_valid && rd.valid && (CMP_W'(rd.code) == CMP_W'(probe));
  assign scan_end = lag_valid && lag_last;

  assign dout.valid       = out_valid;
  assign dout.symbol      = out_symbol;
  assign dout.code_error  = out_err;
  assign dout.last_of_run = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bit_cnt    <= '0;
      pending    <= '0;
      len        <= '0;
      scan_idx   <= '0;
      lag_valid  <= 1'b0;
      lag_last   <= 1'b0;
      res_valid  <= 1'b0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && (din.func == FUNC_DECODE)) begin
            byte_q  <= din.data_byte;
            fin_q   <= din.final_byte;
            bit_cnt <= '0;
            state   <= S_APPEND;
          end
        end

        S_APPEND: begin
          pending   <= pending_next;
          len       <= len + LEN_W'(1);
          probe     <= probe_next;
          scan_idx  <= '0;
          lag_valid <= 1'b0;
          lag_last  <= 1'b0;
          state     <= S_SCAN;
        end

        S_SCAN: begin
          scan_idx  <= scan_idx + IDX_W'(1);
          lag_valid <= 1'b1;
          lag_last  <= (scan_idx == IDX_W'(TABLE_ENTRIES - 1));
          if (hit) begin
            res_valid  <= 1'b1;
            res_symbol <= rd.symbol;
            res_err    <= 1'b0;
            pending    <= '0;
            len        <= '0;
            state      <= S_COMMIT;
          end else if (scan_end) begin
            if (len == LEN_W'(MAX_CODE_LEN)) begin
              res_valid  <= 1'b1;
              res_symbol <= '0;
              res_err    <= 1'b1;
              pending    <= '0;
              len        <= '0;
            end else begin
              res_valid <= 1'b0;
            end
            state <= S_COMMIT;
          end
        end

        S_COMMIT: begin
          if (!(res_valid && held_valid && !out_free)) begin
            if (res_valid && held_valid) begin
              out_symbol <= held_symbol;
              out_err    <= held_err;
              out_last   <= 1'b0;
            end
            if (res_valid) begin
              held_valid  <= 1'b1;
              held_symbol <= res_symbol;
              held_err    <= res_err;
            end
            if (bit_cnt == BIT_W'(BYTE_W - 1)) begin
              state <= S_FLUSH;
            end else begin
              bit_cnt <= bit_cnt + BIT_W'(1);
              state   <= S_APPEND;
            end
          end
        end

        S_FLUSH: begin
          if (!(held_valid && !out_free)) begin
            if (held_valid) begin
              out_symbol <= held_symbol;
              out_err    <= held_err;
              out_last   <= 1'b1;
            end
            held_valid <= 1'b0;
            if (fin_q) begin
              pending <= '0;
              len     <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/huffman_table_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_table_decoder: table-match Huffman decoder
// Loads marker-prefixed codes into a table and decodes data bytes LSB first.
// ----------------------------------------------------------------------------
// A table-write request is taken while the decoder is idle and returns
// nothing. A decode request takes its eight bits one at a time: each bit
// extends the pending code, then a sweep of the code table through its single
// read port with one comparator, one entry per cycle, which stops at the first
// match, then a commit step hands on any result; a stalled result channel
// can hold the commit. Results of a byte leave through an output register,
// the last one marked with last_of_run, so the final result of a byte is
// released only once its eighth bit is done. Table entries read as empty
// after reset at once.
module huffman_table_decoder (
  input  logic       clk,
  input  logic       rst,
  hufd_in_if.sink    din,
  hufd_out_if.source dout
);
  import hufd_pkg::*;

  tbl_wr_t          wr;
  tbl_rd_t          rd;
  logic [IDX_W-1:0] rd_addr;

  hufd_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .din     (din),
    .dout    (dout),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  hufd_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

endmodule
